FILE: rtl/core/atsp_pkg.sv
// ----------------------------------------------------------------------------
// atsp_pkg
// shared types and constants for the abbreviation table stream parser
// ----------------------------------------------------------------------------
`default_nettype none

package atsp_pkg;

    // record kinds carried on the result channel
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_PAIR     = 3'd1;
    localparam logic [2:0] KIND_LIST_END = 3'd2;
    localparam logic [2:0] KIND_SET_END  = 3'd3;
    localparam logic [2:0] KIND_DATA_END = 3'd4;

    // leb128 byte layout
    localparam logic [7:0] LEB_PAYLOAD_MASK = 8'h7f;
    localparam logic [7:0] LEB_CONT_BIT     = 8'h80;

    localparam int OUT_VALUE_W = 32;

    typedef struct packed {
        logic [2:0]             record_kind;
        logic [OUT_VALUE_W-1:0] first_value;
        logic [OUT_VALUE_W-1:0] second_value;
        logic [7:0]             children_byte;
        logic                   value_overflow;
        logic                   at_end;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/atsp_leb_acc.sv
// ----------------------------------------------------------------------------
// atsp_leb_acc
// one step of unsigned leb128 accumulation: merges the 7 payload bits of a
// byte at the current bit position and flags bits that fall off the top
// ----------------------------------------------------------------------------
`default_nettype none

module atsp_leb_acc #(
    parameter int NUMBER_WIDTH = 32,
    parameter int POS_W        = $clog2(NUMBER_WIDTH + 1)
) (
    input  wire logic [NUMBER_WIDTH-1:0] i_acc,
    input  wire logic [POS_W-1:0]        i_bit_pos,
    input  wire logic [7:0]              i_byte,
    output logic      [NUMBER_WIDTH-1:0] o_acc,
    output logic      [POS_W-1:0]        o_bit_pos,
    output logic      [NUMBER_WIDTH-1:0] o_value,
    output logic                         o_overflow,
    output logic                         o_done
);

    logic [7:0]              w_payload;
    logic [NUMBER_WIDTH+6:0] w_shifted;
    logic [POS_W:0]          w_pos_sum;
    logic [POS_W-1:0]        w_pos_sat;

    assign w_payload = i_byte & atsp_pkg::LEB_PAYLOAD_MASK;
    assign w_shifted = {{NUMBER_WIDTH{1'b0}}, w_payload[6:0]} << i_bit_pos;

    assign o_value    = i_acc | w_shifted[NUMBER_WIDTH-1:0];
    assign o_overflow = |w_shifted[NUMBER_WIDTH+6:NUMBER_WIDTH];
    assign o_done     = (i_byte & atsp_pkg::LEB_CONT_BIT) == 8'h00;

    // bit position saturates at the kept width
    assign w_pos_sum = {1'b0, i_bit_pos} + (POS_W+1)'(7);
    assign w_pos_sat = (w_pos_sum > (POS_W+1)'(NUMBER_WIDTH)) ? POS_W'(NUMBER_WIDTH)
                                                               : w_pos_sum[POS_W-1:0];

    assign o_acc     = o_done ? '0 : o_value;
    assign o_bit_pos = o_done ? '0 : w_pos_sat;

endmodule

`default_nettype wire

FILE: rtl/core/atsp_decoder.sv
// ----------------------------------------------------------------------------
// atsp_decoder
// entry parser: tracks where in an abbreviation entry the stream is, holds
// the code, tag and attribute name, and forms one result per finished record
// ----------------------------------------------------------------------------
`default_nettype none

module atsp_decoder #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_end_of_data,
    output logic                   o_res_valid,
    output atsp_pkg::t_result      o_res
);

    localparam int POS_W = $clog2(NUMBER_WIDTH + 1);
    localparam int OUT_W = atsp_pkg::OUT_VALUE_W;

    localparam logic [2:0] PH_CODE  = 3'd0;
    localparam logic [2:0] PH_TAG   = 3'd1;
    localparam logic [2:0] PH_CHILD = 3'd2;
    localparam logic [2:0] PH_NAME  = 3'd3;
    localparam logic [2:0] PH_FORM  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    logic [2:0]              r_phase,      n_phase;
    logic [NUMBER_WIDTH-1:0] r_acc,        n_acc;
    logic [POS_W-1:0]        r_bit_pos,    n_bit_pos;
    logic [NUMBER_WIDTH-1:0] r_held_first, n_held_first;
    logic [NUMBER_WIDTH-1:0] r_held_tag,   n_held_tag;
    logic                    r_ovf,        n_ovf;

    logic [NUMBER_WIDTH-1:0] w_leb_acc;
    logic [POS_W-1:0]        w_leb_pos;
    logic [NUMBER_WIDTH-1:0] w_leb_value;
    logic                    w_leb_ovf;
    logic                    w_leb_done;

    // zero-extend then cut to the result field width
    logic [NUMBER_WIDTH+OUT_W-1:0] w_first_ext, w_tag_ext, w_value_ext;
    logic [OUT_W-1:0]              w_first_out, w_tag_out, w_value_out;

    logic                    w_ovf_base;
    logic                    w_ovf_cur;

    atsp_leb_acc #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .POS_W        (POS_W)
    ) u_leb (
        .i_acc      (r_acc),
        .i_bit_pos  (r_bit_pos),
        .i_byte     (i_data_byte),
        .o_acc      (w_leb_acc),
        .o_bit_pos  (w_leb_pos),
        .o_value    (w_leb_value),
        .o_overflow (w_leb_ovf),
        .o_done     (w_leb_done)
    );

    assign w_first_ext = {{OUT_W{1'b0}}, r_held_first};
    assign w_tag_ext   = {{OUT_W{1'b0}}, r_held_tag};
    assign w_value_ext = {{OUT_W{1'b0}}, w_leb_value};
    assign w_first_out = w_first_ext[OUT_W-1:0];
    assign w_tag_out   = w_tag_ext[OUT_W-1:0];
    assign w_value_out = w_value_ext[OUT_W-1:0];

    // a fresh code starts a new record, so its overflow history is dropped
    assign w_ovf_base = (r_phase == PH_CODE && r_bit_pos == '0 && r_acc == '0) ? 1'b0 : r_ovf;
    assign w_ovf_cur  = w_ovf_base | w_leb_ovf;

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_bit_pos    = r_bit_pos;
        n_held_first = r_held_first;
        n_held_tag   = r_held_tag;
        n_ovf        = r_ovf;
        o_res_valid  = 1'b0;
        o_res        = '0;

        case (r_phase)
            PH_CODE: begin
                n_acc     = w_leb_acc;
                n_bit_pos = w_leb_pos;
                n_ovf     = w_ovf_cur;
                if (w_leb_done) begin
                    if (w_leb_value == '0) begin
                        o_res_valid          = 1'b1;
                        o_res.record_kind    = atsp_pkg::KIND_SET_END;
                        o_res.value_overflow = w_ovf_cur;
                        n_phase              = PH_DONE;
                    end else begin
                        n_held_first = w_leb_value;
                        n_phase      = PH_TAG;
                    end
                end
            end
            PH_TAG: begin
                n_acc     = w_leb_acc;
                n_bit_pos = w_leb_pos;
                n_ovf     = w_ovf_cur;
                if (w_leb_done) begin
                    n_held_tag = w_leb_value;
                    n_phase    = PH_CHILD;
                end
            end
            PH_CHILD: begin
                o_res_valid          = 1'b1;
                o_res.record_kind    = atsp_pkg::KIND_HEADER;
                o_res.first_value    = w_first_out;
                o_res.second_value   = w_tag_out;
                o_res.children_byte  = i_data_byte;
                o_res.value_overflow = r_ovf;
                n_ovf                = 1'b0;
                n_phase              = PH_NAME;
            end
            PH_NAME: begin
                n_acc     = w_leb_acc;
                n_bit_pos = w_leb_pos;
                n_ovf     = w_ovf_cur;
                if (w_leb_done) begin
                    n_held_first = w_leb_value;
                    n_phase      = PH_FORM;
                end
            end
            PH_FORM: begin
                n_acc     = w_leb_acc;
                n_bit_pos = w_leb_pos;
                n_ovf     = w_ovf_cur;
                if (w_leb_done) begin
                    o_res_valid          = 1'b1;
                    o_res.value_overflow = w_ovf_cur;
                    n_ovf                = 1'b0;
                    if (r_held_first == '0 && w_leb_value == '0) begin
                        o_res.record_kind = atsp_pkg::KIND_LIST_END;
                        n_phase           = PH_CODE;
                    end else begin
                        o_res.record_kind  = atsp_pkg::KIND_PAIR;
                        o_res.first_value  = w_first_out;
                        o_res.second_value = w_value_out;
                        n_phase            = PH_NAME;
                    end
                end
            end
            default: begin
                // set ended: bytes are dropped until the final one
            end
        endcase

        o_res.at_end = i_end_of_data;

        if (i_end_of_data) begin
            if (!o_res_valid) begin
                o_res_valid        = 1'b1;
                o_res              = '0;
                o_res.record_kind  = atsp_pkg::KIND_DATA_END;
                o_res.at_end       = 1'b1;
            end
            n_phase      = PH_CODE;
            n_acc        = '0;
            n_bit_pos    = '0;
            n_held_first = '0;
            n_held_tag   = '0;
            n_ovf        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CODE;
            r_acc        <= '0;
            r_bit_pos    <= '0;
            r_held_first <= '0;
            r_held_tag   <= '0;
            r_ovf        <= 1'b0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_bit_pos    <= n_bit_pos;
            r_held_first <= n_held_first;
            r_held_tag   <= n_held_tag;
            r_ovf        <= n_ovf;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/atsp_out_buf.sv
// ----------------------------------------------------------------------------
// atsp_out_buf
// result register with a skid entry behind it, so a request is taken in the
// same cycle that a stalled result still sits on the output
// ----------------------------------------------------------------------------
`default_nettype none

module atsp_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire atsp_pkg::t_result i_push_data,
    input  wire logic              i_stall,
    output logic                   o_full,
    output logic                   o_valid,
    output atsp_pkg::t_result      o_data
);

    logic              r_main_valid;
    logic              r_skid_valid;
    atsp_pkg::t_result r_main;
    atsp_pkg::t_result r_skid;
    logic              w_pop;

    assign w_pop   = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload moves without reset
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_main <= r_skid_valid ? r_skid : i_push_data;
        end else if (!r_main_valid) begin
            r_main <= i_push_data;
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/abbrev_table_stream_parser.sv
// ----------------------------------------------------------------------------
// abbrev_table_stream_parser
// streaming decoder for a debug abbreviation table, one byte per request
// ----------------------------------------------------------------------------
// Takes one byte per cycle while o_stall is low: each byte is decoded in the
// cycle it is accepted (leb128 merge plus entry phase update) and any record
// it completes is registered into the result register, or into its one skid
// entry while a result is stalled there, so input continues; o_stall rises
// only once both entries hold results. Numbers keep NUMBER_WIDTH bits,
// higher bits set value_overflow, and values are cut to 32 bits on the
// output. The end_of_data byte always returns the parser to its reset state
// and always produces exactly one result.
// ----------------------------------------------------------------------------
`default_nettype none

module abbrev_table_stream_parser #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_record_kind,
    output logic [31:0]      o_first_value,
    output logic [31:0]      o_second_value,
    output logic [7:0]       o_children_byte,
    output logic             o_value_overflow,
    output logic             o_at_end
);

    logic              w_take;
    logic              w_res_valid;
    logic              w_full;
    atsp_pkg::t_result w_res;
    atsp_pkg::t_result w_out;

    assign o_stall = w_full;
    assign w_take  = i_valid && !w_full;

    atsp_decoder #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    atsp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_take && w_res_valid),
        .i_push_data (w_res),
        .i_stall     (i_stall),
        .o_full      (w_full),
        .o_valid     (o_valid),
        .o_data      (w_out)
    );

    assign o_record_kind    = w_out.record_kind;
    assign o_first_value    = w_out.first_value;
    assign o_second_value   = w_out.second_value;
    assign o_children_byte  = w_out.children_byte;
    assign o_value_overflow = w_out.value_overflow;
    assign o_at_end         = w_out.at_end;

endmodule

`default_nettype wire

FILE: rtl/core/atsp_checker.sv
// ----------------------------------------------------------------------------
// atsp_checker
// port-level checks on the abbreviation table stream parser
// ----------------------------------------------------------------------------
`default_nettype none

module atsp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_data,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [2:0]  o_record_kind,
    input  wire logic [31:0] o_first_value,
    input  wire logic [31:0] o_second_value,
    input  wire logic [7:0]  o_children_byte,
    input  wire logic        o_value_overflow,
    input  wire logic        o_at_end
);

    // input backs up only when a result is already stuck on the output
    a_stall_needs_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    a_valid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_payload_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_record_kind) && $stable(o_first_value)
            && $stable(o_second_value) && $stable(o_children_byte)
            && $stable(o_value_overflow) && $stable(o_at_end))
        else $error("stalled result changed");

    a_data_end_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == atsp_pkg::KIND_DATA_END |->
            o_at_end && o_first_value == 32'd0 && o_second_value == 32'd0
            && o_children_byte == 8'd0 && !o_value_overflow)
        else $error("malformed data end record");

    a_children_only_header : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind != atsp_pkg::KIND_HEADER |-> o_children_byte == 8'd0)
        else $error("children byte outside a header record");

endmodule

bind abbrev_table_stream_parser atsp_checker u_atsp_checker (.*);

`default_nettype wire

FILE: sim/abbrev_record_checker.sv
// ----------------------------------------------------------------------------
// abbrev_record_checker
// watches both channels of the abbreviation table parser and checks results
// ----------------------------------------------------------------------------
// Every accepted request byte goes through a software copy of the parser. The
// copy decodes leb128 numbers and tracks the entry phase, and queues the
// record that the byte completes. Each accepted result is compared field by
// field with the oldest queued record. Mismatches are counted and handed to
// the top through o_fail_count. The number of records still owed is on
// o_pending.
// ----------------------------------------------------------------------------

module abbrev_record_checker #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_record_kind,
    input  logic [31:0] i_first_value,
    input  logic [31:0] i_second_value,
    input  logic [7:0]  i_children_byte,
    input  logic        i_value_overflow,
    input  logic        i_at_end,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        EXPECT_CODE,
        EXPECT_TAG,
        EXPECT_CHILDREN,
        EXPECT_NAME,
        EXPECT_FORM,
        SET_ENDED
    } t_parse_phase;

    t_parse_phase phase;
    logic [63:0]  number_acc;
    int           bit_pos;
    logic [63:0]  held_first;
    logic [63:0]  held_tag;
    logic         overflow_seen;

    atsp_pkg::t_result expected_records[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_parser();
        phase         = EXPECT_CODE;
        number_acc    = '0;
        bit_pos       = 0;
        held_first    = '0;
        held_tag      = '0;
        overflow_seen = 1'b0;
    endfunction

    // merges one leb128 byte, returns 1 when the number is complete
    function automatic bit leb_merge(input logic [7:0] b, output logic [63:0] value);
        for (int i = 0; i < 7; i++) begin
            if (b[i]) begin
                if (bit_pos + i < NUMBER_WIDTH && bit_pos + i < 64)
                    number_acc[bit_pos + i] = 1'b1;
                else
                    overflow_seen = 1'b1;
            end
        end
        bit_pos = (bit_pos + 7 > NUMBER_WIDTH) ? NUMBER_WIDTH : bit_pos + 7;
        value = number_acc;
        if ((b & atsp_pkg::LEB_CONT_BIT) != 0)
            return 1'b0;
        number_acc = '0;
        bit_pos    = 0;
        return 1'b1;
    endfunction

    function automatic void predict_record(input logic [7:0] b, input logic last_byte);
        logic [63:0]       value;
        atsp_pkg::t_result rec;
        bit                produced;
        produced = 1'b0;
        rec      = '0;
        case (phase)
            EXPECT_CODE: begin
                // a fresh code starts a fresh record for the overflow flag
                if (bit_pos == 0 && number_acc == 0)
                    overflow_seen = 1'b0;
                if (leb_merge(b, value)) begin
                    if (value == 0) begin
                        rec.record_kind    = atsp_pkg::KIND_SET_END;
                        rec.value_overflow = overflow_seen;
                        produced           = 1'b1;
                        phase              = SET_ENDED;
                    end else begin
                        held_first = value;
                        phase      = EXPECT_TAG;
                    end
                end
            end
            EXPECT_TAG: begin
                if (leb_merge(b, value)) begin
                    held_tag = value;
                    phase    = EXPECT_CHILDREN;
                end
            end
            EXPECT_CHILDREN: begin
                rec.record_kind    = atsp_pkg::KIND_HEADER;
                rec.first_value    = held_first[31:0];
                rec.second_value   = held_tag[31:0];
                rec.children_byte  = b;
                rec.value_overflow = overflow_seen;
                produced           = 1'b1;
                overflow_seen      = 1'b0;
                phase              = EXPECT_NAME;
            end
            EXPECT_NAME: begin
                if (leb_merge(b, value)) begin
                    held_first = value;
                    phase      = EXPECT_FORM;
                end
            end
            EXPECT_FORM: begin
                if (leb_merge(b, value)) begin
                    if (held_first == 0 && value == 0) begin
                        rec.record_kind = atsp_pkg::KIND_LIST_END;
                        phase           = EXPECT_CODE;
                    end else begin
                        rec.record_kind  = atsp_pkg::KIND_PAIR;
                        rec.first_value  = held_first[31:0];
                        rec.second_value = value[31:0];
                        phase            = EXPECT_NAME;
                    end
                    rec.value_overflow = overflow_seen;
                    produced           = 1'b1;
                    overflow_seen      = 1'b0;
                end
            end
            default: ;
        endcase
        if (last_byte) begin
            if (!produced) begin
                rec             = '0;
                rec.record_kind = atsp_pkg::KIND_DATA_END;
                produced        = 1'b1;
            end
            clear_parser();
        end
        if (produced) begin
            rec.at_end = last_byte;
            expected_records.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < 100)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_records.delete();
        end else begin
            if (i_valid && !i_in_stall)
                predict_record(i_data_byte, i_end_of_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("unexpected result, kind", 32'(i_record_kind), '0);
                end else begin
                    atsp_pkg::t_result want;
                    want = expected_records.pop_front();
                    if (i_record_kind !== want.record_kind)
                        report_mismatch("record_kind", 32'(i_record_kind), 32'(want.record_kind));
                    if (i_first_value !== want.first_value)
                        report_mismatch("first_value", i_first_value, want.first_value);
                    if (i_second_value !== want.second_value)
                        report_mismatch("second_value", i_second_value, want.second_value);
                    if (i_children_byte !== want.children_byte)
                        report_mismatch("children_byte", 32'(i_children_byte),
                                        32'(want.children_byte));
                    if (i_value_overflow !== want.value_overflow)
                        report_mismatch("value_overflow", 32'(i_value_overflow),
                                        32'(want.value_overflow));
                    if (i_at_end !== want.at_end)
                        report_mismatch("at_end", 32'(i_at_end), 32'(want.at_end));
                end
            end
        end
        o_pending = expected_records.size();
    end

endmodule

FILE: sim/tb_abbrev_table_stream_parser.sv
// ----------------------------------------------------------------------------
// tb_abbrev_table_stream_parser
// stimulus and verdict for the abbreviation table stream parser
// ----------------------------------------------------------------------------
// A short directed stream covers the value extremes, padded and overlong
// numbers, the set end and the final byte in several positions. Random
// abbreviation sets follow, mostly well formed, some cut short by the final
// byte, some plain noise. The sender works in bursts and the receiver stalls
// on its own pattern, with one long hold-off that backs the parser up. The
// checker module does all the predicting and comparing.
// ----------------------------------------------------------------------------

module tb_abbrev_table_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 1200;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 10;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [7:0]  i_data_byte     = 8'h00;
    logic        i_end_of_data   = 1'b0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_record_kind;
    logic [31:0] o_first_value;
    logic [31:0] o_second_value;
    logic [7:0]  o_children_byte;
    logic        o_value_overflow;
    logic        o_at_end;

    int fail_count;
    int pending_records;
    int burst_left = 0;

    logic [7:0] table_bytes[$];

    // bit 8 flags the final byte of the data region
    logic [8:0] directed_bytes[$] = {
        9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h00f,  // code 0xffffffff
        9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h07f,  // tag with bits past 32
        9'h0ff,                                  // children byte
        9'h080, 9'h000, 9'h005,                  // padded zero name, form 5
        9'h000, 9'h000,                          // attribute list end
        9'h000,                                  // set end
        9'h17f,                                  // final byte while ignoring
        9'h185,                                  // final byte mid number
        9'h100,                                  // set end on the final byte
        9'h080, 9'h080, 9'h080, 9'h080, 9'h010,  // code cut down to zero
        9'h1c3                                   // ignored final byte
    };

    abbrev_table_stream_parser DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_data    (i_end_of_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_record_kind    (o_record_kind),
        .o_first_value    (o_first_value),
        .o_second_value   (o_second_value),
        .o_children_byte  (o_children_byte),
        .o_value_overflow (o_value_overflow),
        .o_at_end         (o_at_end)
    );

    abbrev_record_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_in_stall       (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_data    (i_end_of_data),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_record_kind    (o_record_kind),
        .i_first_value    (o_first_value),
        .i_second_value   (o_second_value),
        .i_children_byte  (o_children_byte),
        .i_value_overflow (o_value_overflow),
        .i_at_end         (o_at_end),
        .o_fail_count     (fail_count),
        .o_pending        (pending_records)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] pick_number();
        case ($urandom_range(0, 11))
            0:          return 64'd0;
            1, 2, 3, 4: return 64'($urandom_range(1, 127));
            5, 6:       return 64'($urandom_range(128, 65535));
            7:          return {32'd0, $urandom()};
            8:          return 64'hffff_ffff;
            9:          return {$urandom(), $urandom()};
            10:         return {32'($urandom_range(1, 255)), 32'd0};  // truncates to zero
            default:    return 64'($urandom_range(1, 31));
        endcase
    endfunction

    // leb128 encoding, now and then padded with redundant zero groups
    function automatic void put_number(input logic [63:0] value);
        logic [63:0] rest;
        int          groups;
        rest   = value >> 7;
        groups = 1;
        while (rest != 0) begin
            groups++;
            rest = rest >> 7;
        end
        if ($urandom_range(0, 7) == 0)
            groups += $urandom_range(1, 3);
        rest = value;
        for (int k = 0; k < groups; k++) begin
            table_bytes.push_back({(k != groups - 1), rest[6:0]});
            rest = rest >> 7;
        end
    endfunction

    function automatic void build_abbrev_set();
        int entries;
        int pairs;
        entries = $urandom_range(1, 4);
        repeat (entries) begin
            put_number(($urandom_range(0, 5) == 0) ? pick_number()
                                                   : 64'($urandom_range(1, 400)));
            put_number(pick_number());
            table_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                              : 8'($urandom_range(0, 1)));
            pairs = $urandom_range(0, 6);
            repeat (pairs) begin
                put_number(pick_number());
                put_number(pick_number());
            end
            put_number(64'd0);
            put_number(64'd0);
        end
        put_number(64'd0);
        repeat ($urandom_range(0, 3))
            table_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_request(input logic [7:0] b, input logic last_byte);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                i_valid       <= 1'b0;
                i_data_byte   <= 8'($urandom_range(0, 255));
                i_end_of_data <= 1'($urandom_range(0, 1));
                @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_end_of_data <= last_byte;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        burst_left--;
    endtask

    initial begin : stimulus
        int items_sent;
        int choice;
        int cut;
        items_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[k])
            send_request(directed_bytes[k][7:0], directed_bytes[k][8]);

        while (items_sent < RANDOM_ITEMS) begin
            table_bytes.delete();
            choice = $urandom_range(0, 19);
            if (choice < 14) begin
                build_abbrev_set();
            end else if (choice < 17) begin
                // final byte lands somewhere inside the set
                build_abbrev_set();
                cut = $urandom_range(1, table_bytes.size());
                while (table_bytes.size() > cut)
                    void'(table_bytes.pop_back());
            end else begin
                repeat ($urandom_range(1, 20))
                    table_bytes.push_back(8'($urandom_range(0, 255)));
            end
            foreach (table_bytes[k]) begin
                send_request(table_bytes[k], k == table_bytes.size() - 1);
                items_sent++;
            end
        end
        i_valid <= 1'b0;

        // let the checker see the last request before looking at what is owed
        @(posedge i_clk);
        while (pending_records != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : result_stall_pattern
        int mode;
        int span;
        int spans_done;
        spans_done = 0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            // one long hold-off so the parser backs up and stalls its input
            if (spans_done == 4) begin
                repeat (HOLD_OFF_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= 1'($urandom_range(0, 1));
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge i_clk);
            end
            spans_done++;
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
